@@ src/configurable_crc_engine_unit_defines.svh @@
// Assertion macros for the CRC engine.
// Build with NO_ASSERTIONS defined to drop them.
`ifndef CONFIGURABLE_CRC_ENGINE_UNIT_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge, muted while reset is held.
`define CCRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CCRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CCRC_ASSERT(label, clk, rst_n, prop, msg)

`define CCRC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ src/ccrc_pkg.sv @@
package ccrc_pkg;

    // Largest CRC width the datapath supports (8..32; results clamp to 32).
    localparam int MAX_CRC_WIDTH = 32;

    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CRC_W_BITS = 6;

    // width_mode codes; the unused code falls back to 32 bits
    localparam logic [1:0] WM_8  = 2'd0;
    localparam logic [1:0] WM_16 = 2'd1;
    localparam logic [1:0] WM_32 = 2'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WIDTH_MODE     = 3'd0,
        CFG_POLYNOMIAL     = 3'd1,
        CFG_INITIAL_VALUE  = 3'd2,
        CFG_FINAL_XOR      = 3'd3,
        CFG_REFLECT_INPUT  = 3'd4,
        CFG_REFLECT_OUTPUT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]        width_mode;
        logic [DATA_W-1:0] polynomial;
        logic [DATA_W-1:0] initial_value;
        logic [DATA_W-1:0] final_xor;
        logic              reflect_input;
        logic              reflect_output;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_beat;

    // core -> top status
    typedef struct packed {
        logic fire;      // staged beat consumed this cycle
        logic res_valid; // a finished CRC is produced this cycle
        logic busy;      // message in progress
    } t_core_status;

    function automatic logic [CRC_W_BITS-1:0] crc_width(input logic [1:0] mode);
        logic [6:0] w;
        unique case (mode)
            WM_8:    w = 7'd8;
            WM_16:   w = 7'd16;
            default: w = 7'd32;
        endcase
        if (w > 7'(MAX_CRC_WIDTH)) w = 7'(MAX_CRC_WIDTH);
        if (w > 7'd32)             w = 7'd32;
        if (w < 7'd8)              w = 7'd8;
        return w[CRC_W_BITS-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] width_mask(input logic [CRC_W_BITS-1:0] w);
        return {DATA_W{1'b1}} >> (CRC_W_BITS'(DATA_W) - w);
    endfunction

    function automatic logic [DATA_W-1:0] rev32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) r[i] = v[DATA_W-1-i];
        return r;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[i] = v[7-i];
        return r;
    endfunction

endpackage

@@ src/ccrc_cfg_regs.sv @@
module ccrc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ccrc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ccrc_pkg::DATA_W-1:0]       i_cfg_wdata,
    output ccrc_pkg::t_cfg                    o_cfg
);
    import ccrc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_mode     <= WM_32;
            r_cfg.polynomial     <= 32'h04C1_1DB7;
            r_cfg.initial_value  <= 32'hFFFF_FFFF;
            r_cfg.final_xor      <= 32'hFFFF_FFFF;
            r_cfg.reflect_input  <= 1'b1;
            r_cfg.reflect_output <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH_MODE:     r_cfg.width_mode     <= i_cfg_wdata[1:0];
                CFG_POLYNOMIAL:     r_cfg.polynomial     <= i_cfg_wdata;
                CFG_INITIAL_VALUE:  r_cfg.initial_value  <= i_cfg_wdata;
                CFG_FINAL_XOR:      r_cfg.final_xor      <= i_cfg_wdata;
                CFG_REFLECT_INPUT:  r_cfg.reflect_input  <= i_cfg_wdata[0];
                CFG_REFLECT_OUTPUT: r_cfg.reflect_output <= i_cfg_wdata[0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/ccrc_in_stage.sv @@
module ccrc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ccrc_pkg::t_beat i_beat,
    input  logic            i_take,   // core consumes the staged beat
    output logic            o_valid,
    output ccrc_pkg::t_beat o_beat
);
    import ccrc_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    // free, or emptied this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

@@ src/ccrc_core.sv @@
module ccrc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ccrc_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    input  ccrc_pkg::t_beat             i_beat,
    input  logic                        i_out_free,
    output ccrc_pkg::t_core_status      o_status,
    output logic [ccrc_pkg::DATA_W-1:0] o_crc
);
    import ccrc_pkg::*;

    logic                  r_busy;
    logic [DATA_W-1:0]     r_remainder;
    logic [DATA_W-1:0]     n_remainder;
    logic                  n_busy;
    logic [CRC_W_BITS-1:0] w;
    logic [DATA_W-1:0]     mask;
    logic [DATA_W-1:0]     top;
    logic [DATA_W-1:0]     rem;
    logic [DATA_W-1:0]     fin;
    logic [7:0]            byte_in;
    logic                  fire;
    logic                  active;

    // only a closing beat needs room in the output register
    assign fire   = i_valid && (i_out_free || !i_beat.end_of_message);
    // an item with neither byte nor end mark leaves everything as is
    assign active = fire && (i_beat.byte_present || i_beat.end_of_message);

    assign w    = crc_width(i_cfg.width_mode);
    assign mask = width_mask(w);
    assign top  = DATA_W'(1) << (w - CRC_W_BITS'(1));

    always_comb begin
        byte_in = i_cfg.reflect_input ? rev8(i_beat.data_byte) : i_beat.data_byte;
        rem     = (r_busy ? r_remainder : i_cfg.initial_value) & mask;
        if (i_beat.byte_present) begin
            rem = rem ^ (DATA_W'(byte_in) << (w - CRC_W_BITS'(8)));
            for (int i = 0; i < 8; i++) begin
                if (|(rem & top)) rem = ((rem << 1) ^ i_cfg.polynomial) & mask;
                else              rem = (rem << 1) & mask;
            end
        end
        // reflection across w bits: full reverse, then drop the unused low bits
        fin = i_cfg.reflect_output ? (rev32(rem) >> (CRC_W_BITS'(DATA_W) - w)) : rem;
        fin = (fin ^ i_cfg.final_xor) & mask;
    end

    always_comb begin
        n_remainder = r_remainder;
        n_busy      = r_busy;
        if (active) begin
            n_remainder = rem;
            n_busy      = !i_beat.end_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remainder <= n_remainder;
    end

    assign o_status.fire      = fire;
    assign o_status.res_valid = fire && i_beat.end_of_message;
    assign o_status.busy      = r_busy;
    assign o_crc              = fin;

endmodule

@@ src/ccrc_out_reg.sv @@
module ccrc_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [ccrc_pkg::DATA_W-1:0] i_data,
    input  logic                        i_ready,
    output logic                        o_free,
    output logic                        o_valid,
    output logic [ccrc_pkg::DATA_W-1:0] o_data
);
    import ccrc_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_data;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ src/configurable_crc_engine_unit.sv @@
// An accepted input beat is registered in the input stage; its CRC is then registered in the output register.
// Throughput: one beat per cycle unless a closing beat waits on a full output register; 8-step update unrolled.
// The output register lets the next beat in while a finished CRC waits on m_axis_tready.
// Reset (i_rst_n low, synchronous): both stages empty, no message in progress,
// configuration back to CRC-32 (poly 04C11DB7, init/xorout FFFFFFFF, both reflections on).
`include "configurable_crc_engine_unit_defines.svh"

module configurable_crc_engine_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [ccrc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ccrc_pkg::DATA_W-1:0]     i_cfg_wdata,
    // byte stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tuser,  // [0] byte_present
    input  logic                            s_axis_tlast,  // end_of_message
    // CRC out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ccrc_pkg::DATA_W-1:0]     m_axis_tdata   // [31:0] crc_result
);
    import ccrc_pkg::*;

    t_cfg              cfg;
    t_beat             in_beat;
    t_beat             stg_beat;
    logic              stg_valid;
    t_core_status      core_st;
    logic [DATA_W-1:0] core_crc;
    logic              out_free;

    // live configuration; the user must write it only while no beat is in flight (the block does not enforce this)
    ccrc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign in_beat.data_byte      = s_axis_tdata;
    assign in_beat.byte_present   = s_axis_tuser;
    assign in_beat.end_of_message = s_axis_tlast;

    // input register: holds one beat, refilled in the same cycle it drains
    ccrc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_beat  (in_beat),
        .i_take  (core_st.fire),
        .o_valid (stg_valid),
        .o_beat  (stg_beat)
    );

    // byte update + finalize; owns the running remainder
    ccrc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (stg_valid),
        .i_beat     (stg_beat),
        .i_out_free (out_free),
        .o_status   (core_st),
        .o_crc      (core_crc)
    );

    // result register toward the master side
    ccrc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (core_st.res_valid),
        .i_data  (core_crc),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

    // A closing beat shows up as the next output beat with the computed CRC.
    `CCRC_ASSERT(a_close_to_out, i_clk, i_rst_n, core_st.res_valid |=> m_axis_tvalid && (m_axis_tdata == $past(core_crc)), "closing beat did not reach the output register")

    // A byte without end mark leaves a message open.
    `CCRC_ASSERT(a_open_busy, i_clk, i_rst_n, core_st.fire && stg_beat.byte_present && !stg_beat.end_of_message |=> core_st.busy, "message not marked in progress")

    // After a close the next beat starts from the initial value.
    `CCRC_ASSERT(a_close_idle, i_clk, i_rst_n, core_st.fire && stg_beat.end_of_message |=> !core_st.busy, "message still open after close")

    // Back-pressure on the slave side only while a beat is staged.
    `CCRC_ASSERT_ALWAYS(a_ready_cause, i_clk, !s_axis_tready |-> stg_valid, "slave side stalled with empty input register")

endmodule
